// ===== rtl/core/urf_pkg.sv =====
// Shared types and constants for the UDP/IPv4 receive filter.
`timescale 1ns / 1ps
`default_nettype none
package urf_pkg;

  localparam int unsigned IP_HDR_BYTES = 20;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  VER_IHL_IPV4 = 8'h45;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  FRAG_HI_MASK = 8'h3f;
  localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
  localparam logic [15:0] SUM_ZERO     = 16'h0000;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // IP header byte offsets of interest
  localparam logic [4:0] REL_VER      = 5'd0;
  localparam logic [4:0] REL_LEN_HI   = 5'd2;
  localparam logic [4:0] REL_LEN_LO   = 5'd3;
  localparam logic [4:0] REL_FRAG_HI  = 5'd6;
  localparam logic [4:0] REL_FRAG_LO  = 5'd7;
  localparam logic [4:0] REL_PROTO    = 5'd9;
  localparam logic [4:0] REL_DST_IP0  = 5'd16;
  localparam logic [4:0] REL_DST_IP3  = 5'd19;

  typedef enum logic [2:0] {
    FLD_NONE    = 3'd0,
    FLD_VER     = 3'd1,
    FLD_LEN_HI  = 3'd2,
    FLD_LEN_LO  = 3'd3,
    FLD_FRAG_HI = 3'd4,
    FLD_FRAG_LO = 3'd5,
    FLD_PROTO   = 3'd6
  } urf_field_t;

  typedef enum logic [2:0] {
    RSN_OK       = 3'd0,
    RSN_ADDRESS  = 3'd1,
    RSN_VERSION  = 3'd2,
    RSN_PROTOCOL = 3'd3,
    RSN_LENGTH   = 3'd4,
    RSN_FRAGMENT = 3'd5,
    RSN_CHECKSUM = 3'd6,
    RSN_SHORT    = 3'd7
  } urf_reason_t;

  // One classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        addr_bad;
    logic        in_hdr;
    logic        hdr_odd;
    urf_field_t  kind;
    logic [15:0] count;
    logic        short_frame;
  } urf_beat_t;

endpackage
`default_nettype wire

// ===== rtl/core/urf_front.sv =====
// Front end: byte position tracking, address compare and header field classification.
`timescale 1ns / 1ps
`default_nettype none
module urf_front #(
  parameter int unsigned HEADER_OFFSET = 14
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  [47:0]            own_mac,
  input  wire  [31:0]            own_ip,
  input  wire  [7:0]             frame_byte,
  input  wire                    frame_end,
  input  wire                    push,
  output urf_pkg::urf_beat_t     beat
);
  import urf_pkg::*;

  localparam logic [15:0] HDR_START   = 16'(HEADER_OFFSET);
  localparam logic [15:0] HDR_END     = 16'(HEADER_OFFSET + IP_HDR_BYTES);
  localparam logic [15:0] SHORT_LIMIT = 16'(HEADER_OFFSET + IP_HDR_BYTES);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] count;
  logic [15:0] rel_full;
  logic [4:0]  rel;
  logic        in_hdr;
  logic        in_mac;
  logic        in_dst_ip;
  logic [2:0]  mac_sel;
  logic [1:0]  ip_sel;
  logic [7:0]  mac_want;
  logic [7:0]  ip_want;
  urf_field_t  kind;

  assign count    = (pos_r == COUNT_MAX) ? COUNT_MAX : pos_r + 16'd1;
  assign rel_full = pos_r - HDR_START;
  assign rel      = rel_full[4:0];
  assign in_hdr   = (pos_r >= HDR_START) && (pos_r < HDR_END);
  assign in_mac   = (pos_r < 16'd6);
  assign in_dst_ip = in_hdr && (rel >= REL_DST_IP0) && (rel <= REL_DST_IP3);

  // first byte on the wire is the most significant
  assign mac_sel  = 3'd5 - pos_r[2:0];
  assign ip_sel   = 2'd3 - rel[1:0];
  assign mac_want = own_mac[{mac_sel, 3'b000} +: 8];
  assign ip_want  = own_ip[{ip_sel, 3'b000} +: 8];

  always_comb begin
    kind = FLD_NONE;
    if (in_hdr) begin
      case (rel)
        REL_VER:     kind = FLD_VER;
        REL_LEN_HI:  kind = FLD_LEN_HI;
        REL_LEN_LO:  kind = FLD_LEN_LO;
        REL_FRAG_HI: kind = FLD_FRAG_HI;
        REL_FRAG_LO: kind = FLD_FRAG_LO;
        REL_PROTO:   kind = FLD_PROTO;
        default:     kind = FLD_NONE;
      endcase
    end
  end

  always_comb begin
    beat.data        = frame_byte;
    beat.last        = frame_end;
    beat.addr_bad    = (in_mac && (frame_byte != mac_want)) ||
                       (in_dst_ip && (frame_byte != ip_want));
    beat.in_hdr      = in_hdr;
    beat.hdr_odd     = rel[0];
    beat.kind        = kind;
    beat.count       = count;
    beat.short_frame = (count < SHORT_LIMIT);
  end

  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = frame_end ? 16'd0 : count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 16'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/urf_queue.sv =====
// Short queue of classified beats between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module urf_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    wr_valid,
  output logic                   wr_ready,
  input  urf_pkg::urf_beat_t     wr_beat,
  output logic                   rd_valid,
  input  wire                    rd_ready,
  output urf_pkg::urf_beat_t     rd_beat
);
  import urf_pkg::*;

  urf_beat_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (cnt_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_beat  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])
    else $error("queue pointers disagree with occupancy");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue occupancy missed a write");

endmodule
`default_nettype wire

// ===== rtl/core/urf_back.sv =====
// Back end: header accumulation, checksum and per-frame verdict with output register.
`timescale 1ns / 1ps
`default_nettype none
module urf_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  output logic                   q_ready,
  input  urf_pkg::urf_beat_t     q_beat,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_accepted,
  output logic [2:0]             out_reject_reason
);
  import urf_pkg::*;

  logic        addr_ok_r, addr_ok_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic        frag_r, frag_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  held_r, held_nxt;

  logic        oval_r, oval_nxt;
  logic        oacc_r, oacc_nxt;
  urf_reason_t orsn_r, orsn_nxt;

  logic        slot_free;
  logic        pop;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  urf_reason_t reason;

  assign slot_free = !oval_r || out_ready;
  assign q_ready   = !q_beat.last || slot_free;
  assign pop       = q_valid && q_ready;

  // ones' complement add with end-around carry
  assign sum_wide = {1'b0, sum_r} + {1'b0, held_r, q_beat.data};
  assign sum_fold = sum_wide[15:0] + 16'(sum_wide[16]);

  always_comb begin
    addr_ok_nxt = addr_ok_r && !q_beat.addr_bad;
    ver_nxt     = ver_r;
    proto_nxt   = proto_r;
    tlen_nxt    = tlen_r;
    frag_nxt    = frag_r;
    sum_nxt     = sum_r;
    held_nxt    = held_r;
    if (q_beat.in_hdr) begin
      case (q_beat.kind)
        FLD_VER:     ver_nxt   = q_beat.data;
        FLD_LEN_HI:  tlen_nxt  = {q_beat.data, tlen_r[7:0]};
        FLD_LEN_LO:  tlen_nxt  = {tlen_r[15:8], q_beat.data};
        FLD_FRAG_HI: frag_nxt  = frag_r || ((q_beat.data & FRAG_HI_MASK) != 8'd0);
        FLD_FRAG_LO: frag_nxt  = frag_r || (q_beat.data != 8'd0);
        FLD_PROTO:   proto_nxt = q_beat.data;
        default:     ;
      endcase
      if (q_beat.hdr_odd) begin
        sum_nxt = sum_fold;
      end else begin
        held_nxt = q_beat.data;
      end
    end
  end

  always_comb begin
    if (q_beat.short_frame) begin
      reason = RSN_SHORT;
    end else if (!addr_ok_nxt) begin
      reason = RSN_ADDRESS;
    end else if (ver_nxt != VER_IHL_IPV4) begin
      reason = RSN_VERSION;
    end else if (proto_nxt != PROTO_UDP) begin
      reason = RSN_PROTOCOL;
    end else if (tlen_nxt > q_beat.count) begin
      reason = RSN_LENGTH;
    end else if (frag_nxt) begin
      reason = RSN_FRAGMENT;
    end else if ((sum_nxt != SUM_GOOD) && (sum_nxt != SUM_ZERO)) begin
      reason = RSN_CHECKSUM;
    end else begin
      reason = RSN_OK;
    end
  end

  always_comb begin
    oval_nxt = oval_r && !out_ready;
    oacc_nxt = oacc_r;
    orsn_nxt = orsn_r;
    if (pop && q_beat.last) begin
      oval_nxt = 1'b1;
      oacc_nxt = (reason == RSN_OK);
      orsn_nxt = reason;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_ok_r <= 1'b1;
      ver_r     <= 8'd0;
      proto_r   <= 8'd0;
      tlen_r    <= 16'd0;
      frag_r    <= 1'b0;
      sum_r     <= 16'd0;
      held_r    <= 8'd0;
      oval_r    <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      if (pop) begin
        if (q_beat.last) begin
          addr_ok_r <= 1'b1;
          ver_r     <= 8'd0;
          proto_r   <= 8'd0;
          tlen_r    <= 16'd0;
          frag_r    <= 1'b0;
          sum_r     <= 16'd0;
          held_r    <= 8'd0;
        end else begin
          addr_ok_r <= addr_ok_nxt;
          ver_r     <= ver_nxt;
          proto_r   <= proto_nxt;
          tlen_r    <= tlen_nxt;
          frag_r    <= frag_nxt;
          sum_r     <= sum_nxt;
          held_r    <= held_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    oacc_r <= oacc_nxt;
    orsn_r <= orsn_nxt;
  end

  assign out_valid         = oval_r;
  assign out_accepted      = oacc_r;
  assign out_reject_reason = orsn_r;

  a_acc_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r |-> (oacc_r == (orsn_r == RSN_OK)))
    else $error("accepted flag disagrees with reason");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !out_ready && q_valid && q_beat.last) |-> !pop)
    else $error("verdict would overwrite a pending result");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_beat.last) |=> (addr_ok_r && (sum_r == SUM_ZERO) && !frag_r))
    else $error("frame state not cleared after final beat");

endmodule
`default_nettype wire

// ===== rtl/core/udp_ipv4_receive_filter_core.sv =====
// Top level of the UDP/IPv4 receive filter: register port, front, queue and back.
// The final byte passes through the queue, then its verdict is registered in the output register that drives out_valid.
// Throughput: one byte per cycle while in_ready is high; the queue and output register decouple the sides.
// A held verdict stalls the queue only on the next frame's final byte.
// Reset: synchronous active-low rst_n clears position, frame state, queue and addresses.
`timescale 1ns / 1ps
`default_nettype none
module udp_ipv4_receive_filter_core #(
  parameter int unsigned HEADER_OFFSET = 14
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_frame_byte,
  input  wire         in_frame_end,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_accepted,
  output logic [2:0]  out_reject_reason,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import urf_pkg::*;

  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic        cfg_wr;
  logic        push;
  logic        q_valid;
  logic        q_ready;
  urf_beat_t   f_beat;
  urf_beat_t   q_beat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= 48'd0;
      own_ip_r  <= 32'd0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_OWN_MAC: own_mac_r <= pwdata[47:0];
        REG_OWN_IP:  own_ip_r  <= pwdata[31:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_OWN_MAC: prdata = {16'd0, own_mac_r};
      REG_OWN_IP:  prdata = {32'd0, own_ip_r};
      default:     prdata = 64'd0;
    endcase
  end

  assign push = in_valid && in_ready;

  urf_front #(
    .HEADER_OFFSET (HEADER_OFFSET)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .own_mac    (own_mac_r),
    .own_ip     (own_ip_r),
    .frame_byte (in_frame_byte),
    .frame_end  (in_frame_end),
    .push       (push),
    .beat       (f_beat)
  );

  urf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_beat  (f_beat),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_beat  (q_beat)
  );

  urf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_beat            (q_beat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_reject_reason (out_reject_reason)
  );

endmodule
`default_nettype wire
